### hw/rtl/tcaf_pkg.sv
package tcaf_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH   = 16;
   localparam int PAYLOAD_WIDTH = 16;
   localparam int PTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // sequence range must exceed twice the depth for the age compare to hold
   localparam int SEQ_BITS      = $clog2(QUEUE_DEPTH) + 2;

   typedef logic [PTR_BITS-1:0]      ptr_type;
   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [SEQ_BITS-1:0]      seq_type;
   typedef logic [PAYLOAD_WIDTH-1:0] payload_type;

   // one stored entry
   typedef struct packed {
      payload_type payload;
      seq_type     seq;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP_ANY = 2'd1,
      OP_POP_C0  = 2'd2,
      OP_POP_C1  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // commands from the sequencer to one class queue
   typedef struct packed {
      logic rd_en;
      logic push;
      logic pop;
   } fifo_cmd_type;

   // status from one class queue
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   // circular pointer advance for any depth
   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

### hw/rtl/tcaf_ram.sv
module tcaf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tcaf_fifo.sv
module tcaf_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  tcaf_pkg::fifo_cmd_type  cmd,
   input  tcaf_pkg::entry_type     wr_entry,
   output tcaf_pkg::entry_type     head_entry,
   output tcaf_pkg::fifo_stat_type stat
);
   import tcaf_pkg::*;

   ptr_type   head_ff, head_in;
   ptr_type   tail_ff, tail_in;
   count_type count_ff, count_in;
   logic [ENTRY_WIDTH-1:0] rd_word;

   // entry storage, read at the head, written at the tail
   tcaf_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_word)
   );

   assign head_entry = entry_type'(rd_word);

   // pointer and fill count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.push) begin
         tail_in  = ptr_next(tail_ff);
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         head_in  = ptr_next(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == COUNT_BITS'(QUEUE_DEPTH));

endmodule

### hw/rtl/two_class_age_ordered_fifo_unit.sv
// Two-class age-ordered queue. For each item, in the cycle after
// start is taken the head entries of both class queues come out of their
// registered-read memories, the push or pop is decided and committed, and the
// result is shown on the rsp_ ports in the next cycle with rsp_valid high for
// exactly that one cycle. busy is high only in the decide cycle, so start may
// be given again while a result is being shown; the receiver cannot hold
// results off. rsp_class0_empty and rsp_class1_empty are valid with rsp_valid.
module two_class_age_ordered_fifo_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_op,
   input  logic                                req_item_class,
   input  logic [tcaf_pkg::PAYLOAD_WIDTH-1:0]  req_payload,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [tcaf_pkg::PAYLOAD_WIDTH-1:0]  rsp_out_payload,
   output logic                                rsp_out_class,
   output logic                                rsp_class0_empty,
   output logic                                rsp_class1_empty
);
   import tcaf_pkg::*;

   state_type     state_ff, state_in;
   op_type        op_ff;
   logic          cls_ff;
   payload_type   payload_ff;
   seq_type       seq_ff, seq_in;

   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   payload_type   rsp_payload_ff, rsp_payload_in;
   logic          rsp_class_ff, rsp_class_in;

   logic          accept;
   fifo_cmd_type  cmd0, cmd1;
   fifo_stat_type stat0, stat1;
   entry_type     head0, head1;
   entry_type     wr_entry;
   seq_type       age_diff;
   logic          pick0;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign wr_entry.payload = payload_ff;
   assign wr_entry.seq     = seq_ff;

   tcaf_fifo u_class0 (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd0),
      .wr_entry   (wr_entry),
      .head_entry (head0),
      .stat       (stat0)
   );

   tcaf_fifo u_class1 (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd1),
      .wr_entry   (wr_entry),
      .head_entry (head1),
      .stat       (stat1)
   );

   // class zero head is older when the modular gap is nonzero and under half
   assign age_diff = head1.seq - head0.seq;
   assign pick0    = (age_diff != '0) && !age_diff[SEQ_BITS-1];

   // sequencer: next state, queue commands and result
   always_comb begin
      state_in       = state_ff;
      seq_in         = seq_ff;
      cmd0           = '0;
      cmd1           = '0;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = STATUS_DONE;
      rsp_payload_in = '0;
      rsp_class_in   = 1'b0;

      // head reads launch with the item
      cmd0.rd_en = accept;
      cmd1.rd_en = accept;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            case (op_ff)
               OP_PUSH: begin
                  if ((cls_ff ? stat1.full : stat0.full)) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     cmd0.push = !cls_ff;
                     cmd1.push = cls_ff;
                     seq_in    = seq_ff + 1'b1;
                  end
               end
               OP_POP_C0: begin
                  if (stat0.empty) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     cmd0.pop       = 1'b1;
                     rsp_payload_in = head0.payload;
                  end
               end
               OP_POP_C1: begin
                  if (stat1.empty) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     cmd1.pop       = 1'b1;
                     rsp_payload_in = head1.payload;
                     rsp_class_in   = 1'b1;
                  end
               end
               OP_POP_ANY: begin
                  if (stat0.empty && stat1.empty) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else if (!stat0.empty && (stat1.empty || pick0)) begin
                     cmd0.pop       = 1'b1;
                     rsp_payload_in = head0.payload;
                  end else begin
                     cmd1.pop       = 1'b1;
                     rsp_payload_in = head1.payload;
                     rsp_class_in   = 1'b1;
                  end
               end
               default: begin
                  rsp_status_in = STATUS_DONE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_type'(req_op);
         cls_ff     <= req_item_class;
         payload_ff <= req_payload;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_class_ff   <= rsp_class_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_payload  = rsp_payload_ff;
   assign rsp_out_class    = rsp_class_ff;

   // queue state after the step is live during the result cycle
   assign rsp_class0_empty = stat0.empty;
   assign rsp_class1_empty = stat1.empty;

endmodule
